### hdl/bdq_pkg.sv
// Shared types and constants for the bounded deque with match erase.
// No dependencies; imported by the interfaces, the top level and the checker.
`default_nettype none

package bdq_pkg;

    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TALLY_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_COUNT      = 3'd4,
        OP_ERASE      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Word returned by a pop on an empty queue.
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd9999;

endpackage : bdq_pkg

`default_nettype wire

### hdl/bdq_cmd_if.sv
// Command channel: valid/ready handshake carrying op and value.
// Depends on bdq_pkg.
`default_nettype none

interface bdq_cmd_if;
    import bdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface : bdq_cmd_if

`default_nettype wire

### hdl/bdq_res_if.sv
// Result channel: valid/ready handshake carrying data, status and counts.
// Depends on bdq_pkg.
`default_nettype none

interface bdq_res_if;
    import bdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic [TALLY_W-1:0]       matches_res;
    logic [TALLY_W-1:0]       occupancy;

    modport source (output valid, output data, output status, output matches_res,
                    output occupancy, input ready);
    modport sink   (input valid, input data, input status, input matches_res,
                    input occupancy, output ready);
endinterface : bdq_res_if

`default_nettype wire

### hdl/bounded_deque_with_match_erase_unit.sv
// Bounded deque of signed 32-bit words with count and order-keeping erase.
// Path: push, empty pop, full push, unused op and count/erase on an empty queue go
//   to S_FIN, pop via S_POP; count and erase read one held entry per cycle in S_SCAN,
//   then S_FIN. One command in flight; S_FIN waits while the output register holds
//   an untaken result, and ready returns as the result enters that register.
// Reset (rst_n, async, active low) clears front pointer, count and control; the
//   store is not cleared, only occupied entries are ever read.
`default_nettype none

module bounded_deque_with_match_erase_unit #(
    parameter int CAPACITY = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    bdq_cmd_if.sink  cmd,
    bdq_res_if.source res
);
    import bdq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,   // waiting for a command beat
        S_POP,    // read data of a pop arrives
        S_SCAN,   // walking entries for count or erase
        S_FIN     // result waits for the output register
    } state_t;

    // front + offset, wrapped into the store; offset never exceeds CAPACITY
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offs);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(offs);
        if (s >= (CW+1)'(CAPACITY))
        begin
            s = s - (CW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_SLOT : p - AW'(1);
    endfunction

    // control
    state_t      state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    // scan bookkeeping
    logic [CW-1:0] idx_reg, idx_next;      // entry whose data is on the read port
    logic [CW-1:0] kept_reg, kept_next;
    logic [AW-1:0] rptr_reg, rptr_next;    // next slot to read
    logic [AW-1:0] wptr_reg, wptr_next;    // next slot to compact into
    logic          erase_reg, erase_next;
    logic signed [WORD_W-1:0] val_reg, val_next;
    // pending result
    logic signed [WORD_W-1:0] pend_data_reg, pend_data_next;
    status_t       pend_status_reg, pend_status_next;
    logic [CW-1:0] pend_match_reg, pend_match_next;
    // output register
    logic          out_valid_reg, out_valid_next;
    logic signed [WORD_W-1:0] out_data_reg, out_data_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [TALLY_W-1:0]  out_match_reg, out_match_next;
    logic [TALLY_W-1:0]  out_occ_reg, out_occ_next;

    // store port
    logic                     mem_we, mem_re;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic signed [WORD_W-1:0] mem_wdata, mem_rdata;

    logic          hit;
    logic          last;
    logic [CW-1:0] kept_inc;
    logic [CW+TALLY_W-1:0] match_wide, occ_wide;   // low 5 bits of the counts

    bdq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cmd.ready       = (state_reg == S_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.data        = out_data_reg;
    assign res.status      = out_status_reg;
    assign res.matches_res = out_match_reg;
    assign res.occupancy   = out_occ_reg;

    assign hit        = (mem_rdata == val_reg);
    assign last       = (idx_reg == count_reg - CW'(1));
    assign kept_inc   = kept_reg + CW'(1);
    assign match_wide = {{TALLY_W{1'b0}}, pend_match_reg};
    assign occ_wide   = {{TALLY_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next       = state_reg;
        front_next       = front_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        kept_next        = kept_reg;
        rptr_next        = rptr_reg;
        wptr_next        = wptr_reg;
        erase_next       = erase_reg;
        val_next         = val_reg;
        pend_data_next   = pend_data_reg;
        pend_status_next = pend_status_reg;
        pend_match_next  = pend_match_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_data_next    = out_data_reg;
        out_status_next  = out_status_reg;
        out_match_next   = out_match_reg;
        out_occ_next     = out_occ_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    val_next         = cmd.value;
                    erase_next       = (cmd.op == OP_ERASE);
                    pend_data_next   = '0;
                    pend_status_next = STATUS_OK;
                    pend_match_next  = '0;
                    state_next       = S_FIN;
                    unique case (cmd.op)
                        OP_PUSH_FRONT:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                pend_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                front_next = slot_dec(front_reg);
                                count_next = count_reg + CW'(1);
                                mem_we     = 1'b1;
                                mem_waddr  = slot_dec(front_reg);
                                mem_wdata  = cmd.value;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                pend_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                mem_we     = 1'b1;
                                mem_waddr  = slot_add(front_reg, count_reg);
                                mem_wdata  = cmd.value;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_data_next   = EMPTY_WORD;
                                pend_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = front_reg;
                                front_next = slot_inc(front_reg);
                                count_next = count_reg - CW'(1);
                                state_next = S_POP;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_data_next   = EMPTY_WORD;
                                pend_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = slot_add(front_reg, count_reg - CW'(1));
                                count_next = count_reg - CW'(1);
                                state_next = S_POP;
                            end
                        end
                        OP_COUNT, OP_ERASE:
                        begin
                            if (count_reg != '0)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = front_reg;
                                rptr_next  = slot_inc(front_reg);
                                wptr_next  = front_reg;
                                idx_next   = '0;
                                kept_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // unused op: plain result, state untouched
                        end
                    endcase
                end
            end

            S_POP:
            begin
                pend_data_next = mem_rdata;
                state_next     = S_FIN;
            end

            S_SCAN:
            begin
                // compaction writes at kept <= idx, reads run ahead at idx+1: no overlap
                if (hit)
                begin
                    pend_match_next = pend_match_reg + CW'(1);
                end
                else if (erase_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wptr_reg;
                    mem_wdata = mem_rdata;
                    wptr_next = slot_inc(wptr_reg);
                    kept_next = kept_inc;
                end

                if (!last)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rptr_reg;
                    rptr_next = slot_inc(rptr_reg);
                    idx_next  = idx_reg + CW'(1);
                end
                else
                begin
                    if (erase_reg)
                    begin
                        count_next = hit ? kept_reg : kept_inc;
                    end
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = pend_data_reg;
                    out_status_next = pend_status_reg;
                    out_match_next  = match_wide[TALLY_W-1:0];
                    out_occ_next    = occ_wide[TALLY_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            front_reg       <= '0;
            count_reg       <= '0;
            idx_reg         <= '0;
            kept_reg        <= '0;
            rptr_reg        <= '0;
            wptr_reg        <= '0;
            erase_reg       <= 1'b0;
            val_reg         <= '0;
            pend_data_reg   <= '0;
            pend_status_reg <= STATUS_OK;
            pend_match_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
            out_status_reg  <= STATUS_OK;
            out_match_reg   <= '0;
            out_occ_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            front_reg       <= front_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            kept_reg        <= kept_next;
            rptr_reg        <= rptr_next;
            wptr_reg        <= wptr_next;
            erase_reg       <= erase_next;
            val_reg         <= val_next;
            pend_data_reg   <= pend_data_next;
            pend_status_reg <= pend_status_next;
            pend_match_reg  <= pend_match_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
            out_status_reg  <= out_status_next;
            out_match_reg   <= out_match_next;
            out_occ_reg     <= out_occ_next;
        end
    end

endmodule : bounded_deque_with_match_erase_unit

`default_nettype wire

### hdl/bdq_store.sv
// Entry store: one write port, one read port with registered read data.
// Depends on bdq_pkg for the word width.
`default_nettype none

module bdq_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [AW-1:0]                    waddr,
    input  wire logic signed [bdq_pkg::WORD_W-1:0] wdata,
    input  wire logic                             re,
    input  wire logic [AW-1:0]                    raddr,
    output      logic signed [bdq_pkg::WORD_W-1:0] rdata
);
    import bdq_pkg::*;

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : bdq_store

`default_nettype wire

### hdl/bdq_checker.sv
// Port-level checks for the deque unit, bound onto the top level.
// Depends on bdq_pkg and bounded_deque_with_match_erase_unit.
`default_nettype none

module bdq_checker #(
    parameter int CAPACITY = 16
) (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             res_valid,
    input wire logic                             res_ready,
    input wire logic signed [bdq_pkg::WORD_W-1:0] res_data,
    input wire logic [bdq_pkg::STATUS_W-1:0]      res_status,
    input wire logic [bdq_pkg::TALLY_W-1:0]       res_matches,
    input wire logic [bdq_pkg::TALLY_W-1:0]       res_occupancy
);
    import bdq_pkg::*;

    // a result beat stays up until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped before taken");

    // a stalled result keeps its payload
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_data) && $stable(res_status)
            && $stable(res_matches) && $stable(res_occupancy))
        else $error("stalled result payload changed");

    // empty pop reports the marker word on an empty queue
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == STATUS_EMPTY |->
            res_data == EMPTY_WORD && res_occupancy == '0 && res_matches == '0)
        else $error("empty pop result inconsistent");

    // dropped push leaves a full queue and no data
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == STATUS_FULL |->
            res_occupancy == TALLY_W'(CAPACITY) && res_data == '0 && res_matches == '0)
        else $error("full push result inconsistent");

endmodule : bdq_checker

bind bounded_deque_with_match_erase_unit bdq_checker #(
    .CAPACITY (CAPACITY)
) u_bdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_data      (res.data),
    .res_status    (res.status),
    .res_matches   (res.matches_res),
    .res_occupancy (res.occupancy)
);

`default_nettype wire

### tb/tb_bounded_deque_with_match_erase_unit.sv
// Self-checking bench for the bounded deque with count and order-keeping erase.
// Depends on bdq_pkg, bdq_cmd_if, bdq_res_if and bounded_deque_with_match_erase_unit.
`timescale 1ns / 100ps

module tb_bounded_deque_with_match_erase_unit;
    import bdq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 200000;
    // quiet cycles after the last result: a full count or erase plus margin
    localparam int TAIL_CYCLES = 2 * DEPTH + 8;
    localparam int RANDOM_BEATS = 500;
    localparam int LONG_HOLD    = 300;

    // op codes the block does not decode; it answers them without touching state
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic [TALLY_W-1:0]       tally;
        logic [TALLY_W-1:0]       occ;
    } deque_result_t;

    // One row of the directed table. has_want marks rows whose answer is typed in.
    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] value;
        int                       reps;
        bit                       has_want;
        logic signed [WORD_W-1:0] w_data;
        logic [STATUS_W-1:0]      w_status;
        logic [TALLY_W-1:0]       w_matches;
        logic [TALLY_W-1:0]       w_occ;
    } dir_row_t;

    logic clk;
    logic rst_n;

    bdq_cmd_if cmd_bus ();
    bdq_res_if res_bus ();

    bounded_deque_with_match_erase_unit #(
        .CAPACITY(DEPTH)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_bus),
        .res  (res_bus)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Deque shadow: circular store, head index and fill level
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] shadow_words [DEPTH];
    logic [3:0]               shadow_head;
    int                       shadow_held;

    deque_result_t results_due [$];
    dir_row_t      dir_rows [$];

    int  mismatch_count;
    int  cycle_count;
    bit  random_phase;

    // coverage tallies for the closing summary
    int  n_beats;
    int  n_full_push;
    int  n_empty_pop;
    int  n_erase_hits;
    int  n_reached_full;
    int  peak_matches;

    function automatic int shadow_slot(int offset);
        return (int'(shadow_head) + offset) % DEPTH;
    endfunction

    function automatic void add_row(input dir_row_t row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Apply one command to the shadow deque and return the answer it owes.
    task automatic apply_deque_op(input logic [OP_W-1:0] op,
                                  input logic signed [WORD_W-1:0] v,
                                  output deque_result_t r);
        int kept;
        int hits;
        logic signed [WORD_W-1:0] w;
        r       = '0;
        hits    = 0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (shadow_held >= DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else if (op == OP_PUSH_FRONT)
                begin
                    shadow_head               = shadow_head - 4'd1;   // wraps mod 16
                    shadow_words[shadow_head] = v;
                    shadow_held++;
                end
                else
                begin
                    shadow_words[shadow_slot(shadow_held)] = v;
                    shadow_held++;
                end
            end
            OP_POP_FRONT:
            begin
                if (shadow_held == 0)
                begin
                    r.data   = EMPTY_WORD;
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    r.data      = shadow_words[shadow_head];
                    shadow_head = shadow_head + 4'd1;
                    shadow_held--;
                end
            end
            OP_POP_BACK:
            begin
                if (shadow_held == 0)
                begin
                    r.data   = EMPTY_WORD;
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    r.data = shadow_words[shadow_slot(shadow_held - 1)];
                    shadow_held--;
                end
            end
            OP_COUNT:
            begin
                for (int i = 0; i < shadow_held; i++)
                    if (shadow_words[shadow_slot(i)] == v)
                        hits++;
            end
            OP_ERASE:
            begin
                // compact survivors toward the head, order kept
                kept = 0;
                for (int i = 0; i < shadow_held; i++)
                begin
                    w = shadow_words[shadow_slot(i)];
                    if (w == v)
                        hits++;
                    else
                    begin
                        shadow_words[shadow_slot(kept)] = w;
                        kept++;
                    end
                end
                shadow_held = kept;
            end
            default: ;
        endcase
        r.tally = hits[TALLY_W-1:0];
        r.occ   = shadow_held[TALLY_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Command sender: bursts of random length, random gaps in between
    // ------------------------------------------------------------------
    int burst_left;

    task automatic send_beat(input logic [OP_W-1:0] op,
                             input logic signed [WORD_W-1:0] v,
                             input bit has_want,
                             input deque_result_t want);
        deque_result_t r;
        if (burst_left == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            // every so often a long unbroken burst
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.op    <= op;
        cmd_bus.value <= v;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        burst_left--;

        // beat accepted at this edge: advance the shadow and queue the answer
        apply_deque_op(op, v, r);
        if (has_want)
            r = want;
        results_due.insert(results_due.size(), r);

        if (op != OP_SPARE_6 && op != OP_SPARE_7)
            n_beats++;
        if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && r.status == STATUS_FULL)
            n_full_push++;
        if ((op == OP_POP_FRONT || op == OP_POP_BACK) && r.status == STATUS_EMPTY)
            n_empty_pop++;
        if (op == OP_ERASE && r.tally != 0)
            n_erase_hits++;
        if (shadow_held == DEPTH)
            n_reached_full++;
        if (int'(r.tally) > peak_matches)
            peak_matches = r.tally;
    endtask

    // ------------------------------------------------------------------
    // Result receiver: rotating stall pattern, plus one long hold-off
    // once the random part starts so the deque backs up into its input
    // ------------------------------------------------------------------
    logic [15:0] stall_pat;
    int          pat_age;
    int          hold_left;
    bit          hold_done;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            res_bus.ready <= 1'b0;
            hold_left--;
        end
        else if (random_phase && !hold_done)
        begin
            res_bus.ready <= 1'b0;
            hold_left = LONG_HOLD - 1;
            hold_done = 1'b1;
        end
        else
        begin
            res_bus.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            pat_age++;
            if (pat_age == 64)
            begin
                pat_age   = 0;
                // a quarter of the windows never stall
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : (16'($urandom) | 16'h0001);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (results_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result beat, expected none, actual data %0d status %0d",
                         $time, $signed(res_bus.data), res_bus.status);
            end
            else
            begin
                want = results_due[0];
                results_due.delete(0);
                if (res_bus.data !== want.data)
                begin
                    mismatch_count++;
                    $display("%0t: data mismatch, expected %0d actual %0d",
                             $time, $signed(want.data), $signed(res_bus.data));
                end
                if (res_bus.status !== want.status)
                begin
                    mismatch_count++;
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, res_bus.status);
                end
                if (res_bus.matches_res !== want.tally)
                begin
                    mismatch_count++;
                    $display("%0t: matches_res mismatch, expected %0d actual %0d",
                             $time, want.tally, res_bus.matches_res);
                end
                if (res_bus.occupancy !== want.occ)
                begin
                    mismatch_count++;
                    $display("%0t: occupancy mismatch, expected %0d actual %0d",
                             $time, want.occ, res_bus.occupancy);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached, %0d results still due",
                     $time, results_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Value picker for the random part: a tiny pool so counts and erases
    // hit often, plus extremes and the empty marker pushed as real data
    // ------------------------------------------------------------------
    function automatic logic signed [WORD_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(0, 3) - 2;
        else if (roll < 75)
        begin
            case ($urandom_range(0, 4))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sd0;
                3: return -32'sd1;
                default: return EMPTY_WORD;
            endcase
        end
        return $signed($urandom);
    endfunction

    // Pick an op; mode biases toward filling, draining, mixed or searching.
    function automatic logic [OP_W-1:0] pick_op(int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
        roll = $urandom_range(0, 99);
        case (mode)
            0:       // fill
                if (roll < 70) return (roll < 35) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                else if (roll < 80) return (roll < 75) ? OP_POP_FRONT : OP_POP_BACK;
                else return (roll < 90) ? OP_COUNT : OP_ERASE;
            1:       // drain
                if (roll < 20) return (roll < 10) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                else if (roll < 80) return (roll < 50) ? OP_POP_FRONT : OP_POP_BACK;
                else return (roll < 90) ? OP_COUNT : OP_ERASE;
            2:       // balanced
                if (roll < 40) return (roll < 20) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                else if (roll < 70) return (roll < 55) ? OP_POP_FRONT : OP_POP_BACK;
                else return (roll < 85) ? OP_COUNT : OP_ERASE;
            default: // search heavy, pushes keep the store busy
                if (roll < 50) return (roll < 25) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                else if (roll < 60) return OP_POP_FRONT;
                else return (roll < 78) ? OP_COUNT : OP_ERASE;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        deque_result_t want;
        deque_result_t none;
        int            mode;
        int            random_beats;
        logic [OP_W-1:0] op;

        rst_n          = 1'b0;
        cmd_bus.valid  = 1'b0;
        cmd_bus.op     = OP_PUSH_BACK;
        cmd_bus.value  = '0;
        res_bus.ready  = 1'b0;
        shadow_head    = '0;
        shadow_held    = 0;
        for (int i = 0; i < DEPTH; i++)
            shadow_words[i] = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        random_phase   = 1'b0;
        burst_left     = 0;
        stall_pat      = 16'hFFFF;
        pat_age        = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        n_beats        = 0;
        n_full_push    = 0;
        n_empty_pop    = 0;
        n_erase_hits   = 0;
        n_reached_full = 0;
        peak_matches   = 0;
        none           = '0;

        // Directed table: op, value, repeats, typed answer?, data, status, matches, occupancy
        // empty queue: pops give the marker, searches find nothing, spare op is a no-op
        add_row('{OP_POP_FRONT,  32'sd0, 1, 1, EMPTY_WORD, STATUS_EMPTY, 0, 0});
        add_row('{OP_POP_BACK,   32'sd0, 1, 1, EMPTY_WORD, STATUS_EMPTY, 0, 0});
        add_row('{OP_COUNT,      32'sd0, 1, 1, 32'sd0, STATUS_OK, 0, 0});
        add_row('{OP_ERASE,      32'sd0, 1, 1, 32'sd0, STATUS_OK, 0, 0});
        add_row('{OP_SPARE_7,    32'sd5, 1, 1, 32'sd0, STATUS_OK, 0, 0});
        // word extremes through both ends
        add_row('{OP_PUSH_FRONT, 32'sh7FFF_FFFF, 1, 1, 32'sd0, STATUS_OK, 0, 1});
        add_row('{OP_PUSH_BACK,  32'sh8000_0000, 1, 1, 32'sd0, STATUS_OK, 0, 2});
        add_row('{OP_POP_FRONT,  32'sd0, 1, 1, 32'sh7FFF_FFFF, STATUS_OK, 0, 1});
        add_row('{OP_POP_BACK,   32'sd0, 1, 1, 32'sh8000_0000, STATUS_OK, 0, 0});
        // fill to the brim: 7 at the head twice, a run of adjacent 7s in the middle
        add_row('{OP_PUSH_FRONT, 32'sd7,  1, 0, 32'sd0, STATUS_OK, 0, 0});
        add_row('{OP_PUSH_BACK,  -32'sd1, 5, 0, 32'sd0, STATUS_OK, 0, 0});
        add_row('{OP_PUSH_BACK,  32'sd7,  3, 0, 32'sd0, STATUS_OK, 0, 0});
        add_row('{OP_PUSH_BACK,  32'sd0,  6, 0, 32'sd0, STATUS_OK, 0, 0});
        add_row('{OP_PUSH_FRONT, 32'sd7,  1, 1, 32'sd0, STATUS_OK, 0, 16});
        // full queue drops pushes at either end
        add_row('{OP_PUSH_BACK,  32'sd1, 1, 1, 32'sd0, STATUS_FULL, 0, 16});
        add_row('{OP_PUSH_FRONT, 32'sd1, 1, 1, 32'sd0, STATUS_FULL, 0, 16});
        add_row('{OP_COUNT,      32'sd7, 1, 1, 32'sd0, STATUS_OK, 5, 16});
        add_row('{OP_SPARE_6,    32'sd7, 1, 1, 32'sd0, STATUS_OK, 0, 16});
        // erase head and adjacent matches, then drain by erasing
        add_row('{OP_ERASE,      32'sd7,  1, 1, 32'sd0, STATUS_OK, 5, 11});
        add_row('{OP_POP_FRONT,  32'sd0,  1, 1, -32'sd1, STATUS_OK, 0, 10});
        add_row('{OP_ERASE,      32'sd0,  1, 1, 32'sd0, STATUS_OK, 6, 4});
        add_row('{OP_ERASE,      -32'sd1, 1, 1, 32'sd0, STATUS_OK, 4, 0});
        // sixteen matches: the widest tally
        add_row('{OP_PUSH_BACK,  32'sd3, 16, 0, 32'sd0, STATUS_OK, 0, 0});
        add_row('{OP_ERASE,      32'sd3, 1, 1, 32'sd0, STATUS_OK, 16, 0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            want = '{dir_rows[k].w_data, dir_rows[k].w_status,
                     dir_rows[k].w_matches, dir_rows[k].w_occ};
            repeat (dir_rows[k].reps)
                send_beat(dir_rows[k].op, dir_rows[k].value, dir_rows[k].has_want, want);
        end

        // Random part; the receiver's long hold-off kicks in here
        random_phase = 1'b1;
        random_beats = 0;
        mode         = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            if (random_beats % 40 == 0)
                mode = $urandom_range(0, 3);
            op = pick_op(mode);
            send_beat(op, pick_value(), 1'b0, none);
            if (op != OP_SPARE_6 && op != OP_SPARE_7)
                random_beats++;
        end
        cmd_bus.valid <= 1'b0;

        while (results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d command beats: %0d dropped pushes, %0d empty pops, full %0d times",
                 n_beats, n_full_push, n_empty_pop, n_reached_full);
        $display("Erases that removed entries: %0d, largest match tally %0d, mismatches %0d",
                 n_erase_hits, peak_matches, mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule : tb_bounded_deque_with_match_erase_unit
